### sv/bced_pkg.sv
// Shared types and constants for the button click event detector.
package bced_pkg;

  // Phase of the press detector
  typedef enum logic [1:0] {
    PH_STANDBY  = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_ACTIVE   = 2'd2
  } phase_t;

  // Event codes carried in each result
  typedef enum logic [3:0] {
    EV_NONE   = 4'd0,
    EV_DOWN   = 4'd1,
    EV_HOLD   = 4'd2,
    EV_UP     = 4'd3,
    EV_CLICK  = 4'd4,
    EV_LONG   = 4'd5,
    EV_DOUBLE = 4'd6,
    EV_TRIPLE = 4'd7,
    EV_MULTI  = 4'd8
  } event_t;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOLD     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENABLED  = 3'd4;

  // Configuration reset values
  localparam logic [15:0] DEBOUNCE_RST = 16'd20;
  localparam logic [15:0] HOLD_RST     = 16'd1000;
  localparam logic [15:0] LONG_RST     = 16'd3000;
  localparam logic [15:0] WINDOW_RST   = 16'd250;

  localparam logic [7:0] CLICK_MAX = 8'd255;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Input transaction
  typedef struct packed {
    logic        raw_level;
    logic [31:0] now_ms;
  } in_t;

  // Output transaction
  typedef struct packed {
    logic [1:0]  phase;
    logic [3:0]  event_code;
    logic [31:0] press_duration_ms;
    logic [7:0]  click_total;
    logic        last_of_run;
  } out_t;

  // One classified sample, as queued for the back end
  typedef struct packed {
    phase_t      phase;
    event_t      first;
    event_t      second;
    logic [31:0] duration;
    logic [7:0]  count;
  } rec_t;

endpackage

### sv/bced_front.sv
// Front end: holds configuration and press state, classifies each sample.
module bced_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  bced_pkg::in_t                     in_data,
  input  logic                              cfg_we,
  input  logic [bced_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bced_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              q_full,
  output logic                              q_push,
  output bced_pkg::rec_t                    q_rec
);

  logic [15:0] debounce_ms;
  logic [15:0] hold_interval_ms;
  logic [15:0] long_click_ms;
  logic [15:0] window_ms;
  logic        enabled;

  bced_pkg::phase_t phase, phase_next;
  logic [31:0] activity_time, activity_time_next;
  logic [31:0] release_time, release_time_next;
  logic [31:0] hold_time, hold_time_next;
  logic [7:0]  click_counter, click_counter_next;
  logic [31:0] active_duration, active_duration_next;
  bced_pkg::event_t first, second;

  logic [31:0] held, since_hold, since_release;
  logic [7:0]  count_inc;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Elapsed times, all modulo 2^32
  assign held          = in_data.now_ms - activity_time;
  assign since_hold    = in_data.now_ms - hold_time;
  assign since_release = in_data.now_ms - release_time;
  assign count_inc     = (click_counter < bced_pkg::CLICK_MAX) ? click_counter + 8'd1
                                                              : click_counter;

  // Next state and events for one sample
  always_comb begin
    phase_next           = phase;
    activity_time_next   = activity_time;
    release_time_next    = release_time;
    hold_time_next       = hold_time;
    click_counter_next   = click_counter;
    active_duration_next = active_duration;
    first                = bced_pkg::EV_NONE;
    second               = bced_pkg::EV_NONE;
    if (!enabled) begin
      phase_next = bced_pkg::PH_STANDBY;
    end else if (in_data.raw_level) begin
      case (phase)
        bced_pkg::PH_STANDBY: begin
          activity_time_next = in_data.now_ms;
          phase_next         = bced_pkg::PH_DEBOUNCE;
        end
        bced_pkg::PH_DEBOUNCE: begin
          if (held > {16'd0, debounce_ms}) begin
            activity_time_next = in_data.now_ms;
            hold_time_next     = in_data.now_ms;
            phase_next         = bced_pkg::PH_ACTIVE;
            first              = bced_pkg::EV_DOWN;
          end
        end
        bced_pkg::PH_ACTIVE: begin
          active_duration_next = held;
          if (since_hold > {16'd0, hold_interval_ms}) begin
            hold_time_next = in_data.now_ms;
            first          = bced_pkg::EV_HOLD;
          end
        end
        default: ;
      endcase
    end else if (phase == bced_pkg::PH_ACTIVE) begin
      // Release: up event plus click class
      active_duration_next = held;
      first                = bced_pkg::EV_UP;
      phase_next           = bced_pkg::PH_STANDBY;
      if (since_release < {16'd0, window_ms}) begin
        click_counter_next = count_inc;
        if (count_inc == 8'd2)      second = bced_pkg::EV_DOUBLE;
        else if (count_inc == 8'd3) second = bced_pkg::EV_TRIPLE;
        else if (count_inc > 8'd3)  second = bced_pkg::EV_MULTI;
      end else begin
        click_counter_next = 8'd1;
        second = (held > {16'd0, long_click_ms}) ? bced_pkg::EV_LONG : bced_pkg::EV_CLICK;
      end
      release_time_next  = in_data.now_ms;
      activity_time_next = in_data.now_ms;
      hold_time_next     = in_data.now_ms;
    end else begin
      phase_next = bced_pkg::PH_STANDBY;
    end
  end

  // Record pushed to the queue
  always_comb begin
    q_rec.phase    = phase_next;
    q_rec.first    = first;
    q_rec.second   = second;
    q_rec.duration = active_duration_next;
    q_rec.count    = click_counter_next;
  end

  // State and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= bced_pkg::PH_STANDBY;
      activity_time    <= '0;
      release_time     <= '0;
      hold_time        <= '0;
      click_counter    <= '0;
      active_duration  <= '0;
      debounce_ms      <= bced_pkg::DEBOUNCE_RST;
      hold_interval_ms <= bced_pkg::HOLD_RST;
      long_click_ms    <= bced_pkg::LONG_RST;
      window_ms        <= bced_pkg::WINDOW_RST;
      enabled          <= 1'b1;
    end else begin
      if (q_push) begin
        phase           <= phase_next;
        activity_time   <= activity_time_next;
        release_time    <= release_time_next;
        hold_time       <= hold_time_next;
        click_counter   <= click_counter_next;
        active_duration <= active_duration_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          bced_pkg::CFG_DEBOUNCE: debounce_ms      <= cfg_data[15:0];
          bced_pkg::CFG_HOLD:     hold_interval_ms <= cfg_data[15:0];
          bced_pkg::CFG_LONG:     long_click_ms    <= cfg_data[15:0];
          bced_pkg::CFG_WINDOW:   window_ms        <= cfg_data[15:0];
          bced_pkg::CFG_ENABLED:  enabled          <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

### sv/bced_queue.sv
// Short queue of classified samples between front and back end.
module bced_queue #(
  parameter int DEPTH = bced_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bced_pkg::rec_t push_rec,
  input  logic           pop,
  output bced_pkg::rec_t head,
  output logic           full,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  bced_pkg::rec_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full  = (fill == CNT_W'(DEPTH));
  assign empty = (fill == '0);
  assign head  = entries[rd_ptr];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_rec;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop)      fill <= fill + CNT_W'(1);
      else if (pop && !push) fill <= fill - CNT_W'(1);
    end
  end

endmodule

### sv/bced_back.sv
// Back end: expands each queued sample into one or two output results.
module bced_back (
  input  logic           clk,
  input  logic           rst,
  input  bced_pkg::rec_t head,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output bced_pkg::out_t out_data
);

  logic load;
  logic sub;   // 1: the first result of the head record has gone out
  logic has_second;

  assign load       = !out_valid || !out_stall;
  assign has_second = (head.second != bced_pkg::EV_NONE);
  assign q_pop      = load && !q_empty && (sub || !has_second);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 1'b0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (!q_empty) sub <= !sub && has_second;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      out_data.phase             <= head.phase;
      out_data.press_duration_ms <= head.duration;
      out_data.click_total       <= head.count;
      out_data.event_code        <= sub ? head.second : head.first;
      out_data.last_of_run       <= sub || !has_second;
    end
  end

endmodule

### sv/button_click_event_detector.sv
// Top level of the button click event detector.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   bced_pkg::in_t  (raw_level, now_ms)
//   out      output     out_valid / out_stall bced_pkg::out_t (phase .. last_of_run)
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// A sample is classified and queued in the cycle it is accepted; a new one
// may follow every cycle while the queue has room.
// The back end sends one result per cycle while out_stall is low: one for most
// samples, two for a release with a click class.
// A stalled output holds its result; the queue absorbs up to QUEUE_DEPTH samples
// before in_stall rises. Synchronous reset restores the default configuration.
module button_click_event_detector #(
  parameter int QUEUE_DEPTH = bced_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  bced_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output bced_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [bced_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bced_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic           q_push, q_pop, q_full, q_empty;
  bced_pkg::rec_t q_rec, q_head;

  bced_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_rec     (q_rec)
  );

  bced_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_rec (q_rec),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  bced_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
